// ===== hdl/bts_pkg.sv =====
// shared types and constants of the buzzer tone sequencer
`default_nettype none
package bts_pkg;

  localparam int unsigned TCLK_W = 27;
  localparam int unsigned HZ_W   = 16;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned GAP_W  = 8;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DIV_CNT_W = $clog2(TCLK_W + 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TCLK_W-1:0] TCLK_RESET     = TCLK_W'(1000000);
  localparam logic [HZ_W-1:0]   BAND_LOW_RESET  = HZ_W'(2500);
  localparam logic [HZ_W-1:0]   BAND_HIGH_RESET = HZ_W'(6200);
  localparam logic [GAP_W-1:0]  GAP_RESET       = GAP_W'(12);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_CLK = 2'd0,
    CFG_BAND_LOW  = 2'd1,
    CFG_BAND_HIGH = 2'd2,
    CFG_GAP       = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TONE = 2'd1,
    PH_GAP  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    OP_TONE = 2'd0,
    OP_REST = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  typedef enum logic {
    BK_READY = 1'b0,
    BK_CALC  = 1'b1
  } back_state_e;

  typedef enum logic [2:0] {
    CALC_IDLE   = 3'd0,
    CALC_HALVE  = 3'd1,
    CALC_DOUBLE = 3'd2,
    CALC_DIVIDE = 3'd3,
    CALC_DONE   = 3'd4
  } calc_state_e;

  typedef struct packed {
    logic             command;
    logic [HZ_W-1:0]  tone_hz;
    logic [DUR_W-1:0] duration_ms;
  } in_t;

  typedef struct packed {
    logic             pwm_on;
    logic [CNT_W-1:0] period_count;
    logic [CNT_W-1:0] compare_count;
    logic             busy_res;
    logic             tone_done;
    logic             rejected;
  } out_t;

  typedef struct packed {
    op_e              op;
    logic [HZ_W-1:0]  hz;
    logic [DUR_W-1:0] dur;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  typedef struct packed {
    logic [TCLK_W-1:0] timer_clk;
    logic [HZ_W-1:0]   band_low;
    logic [HZ_W-1:0]   band_high;
    logic [GAP_W-1:0]  gap;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [HZ_W-1:0] hz;
  } calc_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] reload;
    logic [CNT_W-1:0] compare;
  } calc_sts_t;

endpackage
`default_nettype wire

// ===== hdl/bts_stream_if.sv =====
// valid/ready stream channel carrying one payload
`default_nettype none
interface bts_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/buzzer_tone_sequencer_top.sv =====
// buzzer tone sequencer top: request queue, sequencer and tuning divider
// tick, rest and rejected loads pass the queue register and then the result register, where an out stall can hold them
// a tone load folds by octaves into the band, h halvings and then d doublings at one
// step a cycle, and then runs the one-bit restoring divider over the timer clock
// ticks sustain one per cycle while out is ready; the 2-entry request queue takes requests while out stalls, until full
// reset: config registers to defaults, queue empty, idle with pwm off, no clearing pass
`default_nettype none
module buzzer_tone_sequencer_top #(
  parameter int unsigned FREQ_MULTIPLIER = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bts_pkg::TCLK_W-1:0]    cfg_data_i,
  bts_stream_if.sink                         in_if,
  bts_stream_if.source                       out_if
);

  bts_pkg::head_t     head;
  logic               pop;
  bts_pkg::cfg_t      cfg;
  bts_pkg::calc_req_t calc_req;
  bts_pkg::calc_sts_t calc_sts;

  bts_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .head_o (head),
    .pop_i  (pop)
  );

  bts_calc #(
    .FREQ_MULTIPLIER (FREQ_MULTIPLIER)
  ) u_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (calc_req),
    .sts_o  (calc_sts)
  );

  bts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .head_i     (head),
    .pop_o      (pop),
    .cfg_o      (cfg),
    .calc_req_o (calc_req),
    .calc_sts_i (calc_sts),
    .out_if     (out_if)
  );

endmodule
`default_nettype wire

// ===== hdl/bts_front.sv =====
// request intake: classifies requests and queues them for the sequencer
`default_nettype none
module bts_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  bts_stream_if.sink        in_if,
  output bts_pkg::head_t    head_o,
  input  wire logic         pop_i
);

  localparam int unsigned DEPTH = bts_pkg::QUEUE_DEPTH;

  bts_pkg::entry_t                 mem_q [DEPTH];
  logic [bts_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [bts_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [bts_pkg::QCNT_W-1:0]      count_q, count_d;
  bts_pkg::entry_t                 entry;
  logic                            push;

  assign in_if.ready = (count_q != bts_pkg::QCNT_W'(DEPTH));
  assign push = in_if.valid && in_if.ready;

  // classify once here so the sequencer only dispatches
  always_comb begin
    entry.hz  = in_if.data.tone_hz;
    entry.dur = in_if.data.duration_ms;
    priority if (in_if.data.command == bts_pkg::CMD_TICK) begin
      entry.op = bts_pkg::OP_TICK;
    end else if (in_if.data.tone_hz == '0) begin
      entry.op = bts_pkg::OP_REST;
    end else begin
      entry.op = bts_pkg::OP_TONE;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == bts_pkg::QPTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == bts_pkg::QPTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty request queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bts_pkg::QCNT_W'(DEPTH))
    else $error("request queue count beyond depth");
`endif

endmodule
`default_nettype wire

// ===== hdl/bts_calc.sv =====
// octave fold and restoring divider for the pwm reload and compare values
`default_nettype none
module bts_calc #(
  parameter int unsigned FREQ_MULTIPLIER = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bts_pkg::cfg_t      cfg_i,
  input  wire bts_pkg::calc_req_t req_i,
  output bts_pkg::calc_sts_t      sts_o
);

  localparam int unsigned MW = $clog2(FREQ_MULTIPLIER + 1);
  localparam int unsigned FW = bts_pkg::HZ_W + MW;
  localparam int unsigned TW = bts_pkg::TCLK_W;
  localparam logic [FW-1:0] MULT_F = FW'(FREQ_MULTIPLIER);

  bts_pkg::calc_state_e          state_q, state_d;
  logic [FW-1:0]                 f_q, f_d;
  logic [FW-1:0]                 rem_q, rem_d;
  logic [TW-1:0]                 quo_q, quo_d;
  logic [bts_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [FW:0]                   rem_sh;
  logic                          ge;
  logic [FW-1:0]                 low_f, high_f;
  logic [TW-1:0]                 quo_m1;
  logic [TW-1:0]                 quo_half;

  assign low_f  = FW'(cfg_i.band_low);
  assign high_f = FW'(cfg_i.band_high);

  assign rem_sh = {rem_q, quo_q[TW-1]};
  assign ge     = (rem_sh >= {1'b0, f_q});

  always_comb begin
    state_d = state_q;
    f_d     = f_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    if (req_i.start) begin
      f_d     = {{MW{1'b0}}, req_i.hz} * MULT_F;
      state_d = bts_pkg::CALC_HALVE;
    end else begin
      unique case (state_q)
        bts_pkg::CALC_IDLE, bts_pkg::CALC_DONE: begin
          state_d = state_q;
        end
        bts_pkg::CALC_HALVE: begin
          // halving stops at 1 so a zero upper bound cannot zero the divisor
          if (f_q > high_f && f_q > FW'(1)) begin
            f_d = f_q >> 1;
          end else begin
            state_d = bts_pkg::CALC_DOUBLE;
          end
        end
        bts_pkg::CALC_DOUBLE: begin
          if (f_q < low_f) begin
            f_d = f_q << 1;
          end else begin
            rem_d   = '0;
            quo_d   = cfg_i.timer_clk;
            cnt_d   = bts_pkg::DIV_CNT_W'(TW);
            state_d = bts_pkg::CALC_DIVIDE;
          end
        end
        bts_pkg::CALC_DIVIDE: begin
          rem_d = ge ? FW'(rem_sh - {1'b0, f_q}) : rem_sh[FW-1:0];
          quo_d = {quo_q[TW-2:0], ge};
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == bts_pkg::DIV_CNT_W'(1)) begin
            state_d = bts_pkg::CALC_DONE;
          end
        end
        default: state_d = bts_pkg::CALC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bts_pkg::CALC_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q   <= f_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

  // saturate quotient - 1 and quotient / 2 to the counter width
  assign quo_m1   = quo_q - TW'(1);
  assign quo_half = quo_q >> 1;

  always_comb begin
    sts_o.done = (state_q == bts_pkg::CALC_DONE);
    if (quo_q == '0) begin
      sts_o.reload = '0;
    end else if (quo_m1 > TW'(bts_pkg::CNT_MAX)) begin
      sts_o.reload = bts_pkg::CNT_MAX;
    end else begin
      sts_o.reload = quo_m1[bts_pkg::CNT_W-1:0];
    end
    if (quo_half > TW'(bts_pkg::CNT_MAX)) begin
      sts_o.compare = bts_pkg::CNT_MAX;
    end else begin
      sts_o.compare = quo_half[bts_pkg::CNT_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bts_pkg::CALC_DIVIDE |-> f_q != '0)
    else $error("divide started with zero tuned frequency");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bts_pkg::CALC_DIVIDE && $past(state_q) == bts_pkg::CALC_DIVIDE
    |-> rem_q < f_q)
    else $error("partial remainder not below divisor");
`endif

endmodule
`default_nettype wire

// ===== hdl/bts_back.sv =====
// tone sequencer: config registers, phase timing and the result register
`default_nettype none
module bts_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bts_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bts_pkg::TCLK_W-1:0]      cfg_data_i,
  input  wire bts_pkg::head_t                  head_i,
  output logic                                 pop_o,
  output bts_pkg::cfg_t                        cfg_o,
  output bts_pkg::calc_req_t                   calc_req_o,
  input  wire bts_pkg::calc_sts_t              calc_sts_i,
  bts_stream_if.source                         out_if
);

  bts_pkg::cfg_t                  cfg_q;
  bts_pkg::back_state_e           state_q, state_d;
  bts_pkg::phase_e                phase_q, phase_d;
  logic [bts_pkg::DUR_W-1:0]      rem_q, rem_d;
  logic [bts_pkg::CNT_W-1:0]      reload_q, reload_d;
  logic [bts_pkg::CNT_W-1:0]      compare_q, compare_d;
  logic                           oe_q, oe_d;
  bts_pkg::out_t                  out_q, res;
  logic                           out_valid_q;
  logic                           out_free;
  logic                           res_load;
  logic                           done;
  logic                           rej;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_clk <= bts_pkg::TCLK_RESET;
      cfg_q.band_low  <= bts_pkg::BAND_LOW_RESET;
      cfg_q.band_high <= bts_pkg::BAND_HIGH_RESET;
      cfg_q.gap       <= bts_pkg::GAP_RESET;
    end else if (cfg_we_i) begin
      unique case (bts_pkg::cfg_idx_e'(cfg_idx_i))
        bts_pkg::CFG_TIMER_CLK: cfg_q.timer_clk <= cfg_data_i;
        bts_pkg::CFG_BAND_LOW:  cfg_q.band_low  <= cfg_data_i[bts_pkg::HZ_W-1:0];
        bts_pkg::CFG_BAND_HIGH: cfg_q.band_high <= cfg_data_i[bts_pkg::HZ_W-1:0];
        bts_pkg::CFG_GAP:       cfg_q.gap       <= cfg_data_i[bts_pkg::GAP_W-1:0];
      endcase
    end
  end

  assign cfg_o    = cfg_q;
  assign out_free = !out_valid_q || out_if.ready;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    rem_d     = rem_q;
    reload_d  = reload_q;
    compare_d = compare_q;
    oe_d      = oe_q;
    pop_o     = 1'b0;
    res_load  = 1'b0;
    done      = 1'b0;
    rej       = 1'b0;
    calc_req_o.start = 1'b0;
    calc_req_o.hz    = head_i.entry.hz;
    unique case (state_q)
      bts_pkg::BK_READY: begin
        if (head_i.valid && out_free) begin
          pop_o = 1'b1;
          unique case (head_i.entry.op)
            bts_pkg::OP_TICK: begin
              res_load = 1'b1;
              if (phase_q != bts_pkg::PH_IDLE) begin
                rem_d = (rem_q != '0) ? rem_q - 1'b1 : '0;
                if (rem_d == '0) begin
                  if (phase_q == bts_pkg::PH_TONE) begin
                    compare_d = '0;
                    oe_d      = 1'b0;
                    phase_d   = bts_pkg::PH_GAP;
                    rem_d     = bts_pkg::DUR_W'(cfg_q.gap);
                  end else begin
                    phase_d = bts_pkg::PH_IDLE;
                    done    = 1'b1;
                  end
                end
              end
            end
            bts_pkg::OP_REST: begin
              res_load = 1'b1;
              if (phase_q != bts_pkg::PH_IDLE) begin
                rej = 1'b1;
              end else begin
                compare_d = '0;
                oe_d      = 1'b0;
                phase_d   = bts_pkg::PH_TONE;
                rem_d     = head_i.entry.dur;
              end
            end
            default: begin
              if (phase_q != bts_pkg::PH_IDLE) begin
                res_load = 1'b1;
                rej      = 1'b1;
              end else begin
                // duration parks in the counter while the divider runs
                calc_req_o.start = 1'b1;
                rem_d   = head_i.entry.dur;
                state_d = bts_pkg::BK_CALC;
              end
            end
          endcase
        end
      end
      bts_pkg::BK_CALC: begin
        if (calc_sts_i.done && out_free) begin
          res_load  = 1'b1;
          reload_d  = calc_sts_i.reload;
          compare_d = calc_sts_i.compare;
          oe_d      = 1'b1;
          phase_d   = bts_pkg::PH_TONE;
          state_d   = bts_pkg::BK_READY;
        end
      end
    endcase
  end

  always_comb begin
    res.pwm_on        = oe_d;
    res.period_count  = reload_d;
    res.compare_count = compare_d;
    res.busy_res      = (phase_d != bts_pkg::PH_IDLE);
    res.tone_done     = done;
    res.rejected      = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bts_pkg::BK_READY;
      phase_q     <= bts_pkg::PH_IDLE;
      rem_q       <= '0;
      reload_q    <= '0;
      compare_q   <= '0;
      oe_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      rem_q     <= rem_d;
      reload_q  <= reload_d;
      compare_q <= compare_d;
      oe_q      <= oe_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

`ifndef ASSERT_OFF
  a_pwm_only_in_tone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pwm_on |-> out_q.busy_res)
    else $error("pwm enabled outside a tone");

  a_calc_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bts_pkg::BK_CALC |-> phase_q == bts_pkg::PH_IDLE && !pop_o)
    else $error("divider running while a tone is active");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_buzzer_tone_sequencer_top.sv =====
// testbench of the buzzer tone sequencer: directed and random requests checked against a tone predictor
`timescale 1ns / 100ps
module tb_buzzer_tone_sequencer_top;

  localparam int unsigned FREQ_MULT      = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 80;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  bts_pkg::cfg_idx_e             cfg_idx_i;
  logic [bts_pkg::TCLK_W-1:0]    cfg_data_i;

  bts_stream_if #(.payload_t(bts_pkg::in_t))  tone_req_if ();
  bts_stream_if #(.payload_t(bts_pkg::out_t)) tone_res_if ();

  buzzer_tone_sequencer_top #(.FREQ_MULTIPLIER(FREQ_MULT)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (tone_req_if),
    .out_if     (tone_res_if)
  );

  always #6 clk_i = ~clk_i;

  // register copies used by the predictor
  logic [bts_pkg::TCLK_W-1:0] tclk_hz   = bts_pkg::TCLK_RESET;
  logic [bts_pkg::HZ_W-1:0]   band_low  = bts_pkg::BAND_LOW_RESET;
  logic [bts_pkg::HZ_W-1:0]   band_high = bts_pkg::BAND_HIGH_RESET;
  logic [bts_pkg::GAP_W-1:0]  gap_ms    = bts_pkg::GAP_RESET;

  // sequencer state as predicted
  bts_pkg::phase_e            seq_phase   = bts_pkg::PH_IDLE;
  logic [bts_pkg::DUR_W-1:0]  remaining   = '0;
  logic [bts_pkg::CNT_W-1:0]  reload_cnt  = '0;
  logic [bts_pkg::CNT_W-1:0]  compare_cnt = '0;
  logic                       pwm_en      = 1'b0;

  bts_pkg::in_t  tone_requests[$];
  bts_pkg::out_t due_status[$];
  int unsigned   busy_ticks_left;
  int unsigned   req_idle_pct, res_stall_pct;
  int unsigned   req_idle_left, res_stall_left;
  int unsigned   quiet_cycles;
  int unsigned   failures;
  int unsigned   requests_sent, results_checked, tones_finished;
  int unsigned   tones_loaded, rests_loaded, loads_refused, settings_used;
  bit            timed_out;
  bts_pkg::out_t want, got;

  function automatic bts_pkg::out_t advance_sequencer(input bts_pkg::in_t req);
    bts_pkg::out_t res;
    logic [31:0]   f;
    logic [31:0]   q;
    res = '0;
    if (req.command == bts_pkg::CMD_LOAD) begin
      if (seq_phase != bts_pkg::PH_IDLE) begin
        res.rejected = 1'b1;
        loads_refused++;
      end else begin
        if (req.tone_hz == '0) begin
          compare_cnt = '0;
          pwm_en = 1'b0;
          rests_loaded++;
        end else begin
          // fold by octaves into the band: halve first, then double
          f = 32'(req.tone_hz) * FREQ_MULT;
          while (f > 32'(band_high) && f > 32'd1) f = f >> 1;
          while (f < 32'(band_low)) f = f << 1;
          q = 32'(tclk_hz) / f;
          reload_cnt = (q == 0) ? '0 :
                       ((q - 1 > 32'hFFFF) ? bts_pkg::CNT_MAX : bts_pkg::CNT_W'(q - 1));
          compare_cnt = ((q >> 1) > 32'hFFFF) ? bts_pkg::CNT_MAX : bts_pkg::CNT_W'(q >> 1);
          pwm_en = 1'b1;
          tones_loaded++;
        end
        seq_phase = bts_pkg::PH_TONE;
        remaining = req.duration_ms;
      end
    end else if (seq_phase != bts_pkg::PH_IDLE) begin
      if (remaining != '0) remaining--;
      if (remaining == '0) begin
        if (seq_phase == bts_pkg::PH_TONE) begin
          compare_cnt = '0;
          pwm_en = 1'b0;
          seq_phase = bts_pkg::PH_GAP;
          remaining = bts_pkg::DUR_W'(gap_ms);
        end else begin
          seq_phase = bts_pkg::PH_IDLE;
          res.tone_done = 1'b1;
        end
      end
    end
    res.pwm_on        = pwm_en;
    res.period_count  = reload_cnt;
    res.compare_count = compare_cnt;
    res.busy_res      = (seq_phase != bts_pkg::PH_IDLE);
    return res;
  endfunction

  // queues a request and tracks how many ticks the current tone and its gap still need, only to shape the stimulus
  function automatic void queue_request(input logic cmd,
                                        input logic [bts_pkg::HZ_W-1:0] hz,
                                        input logic [bts_pkg::DUR_W-1:0] dur);
    bts_pkg::in_t req;
    req.command     = cmd;
    req.tone_hz     = hz;
    req.duration_ms = dur;
    tone_requests.push_back(req);
    if (cmd == bts_pkg::CMD_LOAD) begin
      if (busy_ticks_left == 0)
        busy_ticks_left = ((dur == '0) ? 1 : int'(dur)) + ((gap_ms == '0) ? 1 : int'(gap_ms));
    end else if (busy_ticks_left != 0) begin
      busy_ticks_left--;
    end
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      failures++;
      if (failures <= 10)
        $display("result %0d: %s expected %0d, got %0d", results_checked, field,
                 exp_val, act_val);
    end
  endtask

  task automatic wait_drained();
    while (tone_requests.size() != 0 || due_status.size() != 0 || tone_req_if.valid)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input bts_pkg::cfg_idx_e idx,
                           input logic [bts_pkg::TCLK_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      bts_pkg::CFG_TIMER_CLK: tclk_hz   = value;
      bts_pkg::CFG_BAND_LOW:  band_low  = bts_pkg::HZ_W'(value);
      bts_pkg::CFG_BAND_HIGH: band_high = bts_pkg::HZ_W'(value);
      bts_pkg::CFG_GAP:       gap_ms    = bts_pkg::GAP_W'(value);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [bts_pkg::TCLK_W-1:0] tclk,
                                input logic [bts_pkg::HZ_W-1:0] low,
                                input logic [bts_pkg::HZ_W-1:0] high,
                                input logic [bts_pkg::GAP_W-1:0] gap);
    write_reg(bts_pkg::CFG_TIMER_CLK, tclk);
    write_reg(bts_pkg::CFG_BAND_LOW, bts_pkg::TCLK_W'(low));
    write_reg(bts_pkg::CFG_BAND_HIGH, bts_pkg::TCLK_W'(high));
    write_reg(bts_pkg::CFG_GAP, bts_pkg::TCLK_W'(gap));
    settings_used++;
  endtask

  task automatic run_phase(input logic [bts_pkg::TCLK_W-1:0] tclk,
                           input logic [bts_pkg::HZ_W-1:0] low,
                           input logic [bts_pkg::HZ_W-1:0] high,
                           input logic [bts_pkg::GAP_W-1:0] gap,
                           input int unsigned count, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    int unsigned                pick;
    logic [bts_pkg::HZ_W-1:0]   hz;
    logic [bts_pkg::DUR_W-1:0]  dur;
    wait_drained();
    apply_settings(tclk, low, high, gap);
    req_idle_pct  = idle_pct;
    res_stall_pct = stall_pct;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (busy_ticks_left == 0) begin
        if (pick < 8) begin
          queue_request(bts_pkg::CMD_TICK, bts_pkg::HZ_W'($urandom),
                        bts_pkg::DUR_W'($urandom));
        end else begin
          case ($urandom_range(5))
            0:       hz = '0;
            1:       hz = bts_pkg::HZ_W'($urandom_range(15));
            2:       hz = 16'hFFFF - bts_pkg::HZ_W'($urandom_range(15));
            default: hz = bts_pkg::HZ_W'($urandom);
          endcase
          dur = ($urandom_range(3) == 0) ? '0 : bts_pkg::DUR_W'($urandom_range(24));
          queue_request(bts_pkg::CMD_LOAD, hz, dur);
        end
      end else if (pick < 12) begin
        // load in the middle of a tone or gap, turned away
        queue_request(bts_pkg::CMD_LOAD, bts_pkg::HZ_W'($urandom), bts_pkg::DUR_W'($urandom));
      end else begin
        queue_request(bts_pkg::CMD_TICK, bts_pkg::HZ_W'($urandom), bts_pkg::DUR_W'($urandom));
      end
    end
    // let the last tone and its gap run out
    while (busy_ticks_left != 0)
      queue_request(bts_pkg::CMD_TICK, bts_pkg::HZ_W'($urandom), bts_pkg::DUR_W'($urandom));
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tone_req_if.valid && tone_req_if.ready) begin
        due_status.push_back(advance_sequencer(tone_req_if.data));
        requests_sent++;
      end
      if (!tone_req_if.valid || tone_req_if.ready) begin
        if (req_idle_left == 0 && tone_requests.size() != 0 && $urandom_range(99) < req_idle_pct)
          req_idle_left = $urandom_range(18, 1);
        if (req_idle_left != 0) begin
          req_idle_left--;
          tone_req_if.valid <= 1'b0;
        end else if (tone_requests.size() != 0) begin
          tone_req_if.valid <= 1'b1;
          tone_req_if.data  <= tone_requests.pop_front();
        end else begin
          tone_req_if.valid <= 1'b0;
        end
      end
    end
  end

  // status monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tone_req_if.valid && tone_req_if.ready) || (tone_res_if.valid && tone_res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (tone_res_if.valid && tone_res_if.ready) begin
        results_checked++;
        got = tone_res_if.data;
        if (got.tone_done) tones_finished++;
        if (due_status.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("result %0d arrived with no request outstanding", results_checked);
        end else begin
          want = due_status.pop_front();
          check_field("pwm_on", want.pwm_on, got.pwm_on);
          check_field("period_count", want.period_count, got.period_count);
          check_field("compare_count", want.compare_count, got.compare_count);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("tone_done", want.tone_done, got.tone_done);
          check_field("rejected", want.rejected, got.rejected);
        end
      end
      if (res_stall_left == 0 && $urandom_range(99) < res_stall_pct)
        res_stall_left = $urandom_range(18, 1);
      if (res_stall_left != 0) begin
        res_stall_left--;
        tone_res_if.ready <= 1'b0;
      end else begin
        tone_res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = bts_pkg::CFG_TIMER_CLK;
    cfg_data_i        = '0;
    tone_req_if.valid = 1'b0;
    tone_req_if.data  = '0;
    tone_res_if.ready = 1'b0;
    req_idle_pct      = 10;
    res_stall_pct     = 10;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        // directed: zero gap, idle tick, halving, busy load, zero duration, doubling, rest
        apply_settings(bts_pkg::TCLK_RESET, bts_pkg::BAND_LOW_RESET,
                       bts_pkg::BAND_HIGH_RESET, '0);
        queue_request(bts_pkg::CMD_TICK, '0, '0);
        queue_request(bts_pkg::CMD_LOAD, 16'hFFFF, 16'd1);
        queue_request(bts_pkg::CMD_LOAD, 16'h1234, 16'hFFFF);
        repeat (2) queue_request(bts_pkg::CMD_TICK, '1, '1);
        queue_request(bts_pkg::CMD_LOAD, 16'd1, '0);
        repeat (2) queue_request(bts_pkg::CMD_TICK, '0, '0);
        queue_request(bts_pkg::CMD_LOAD, '0, 16'd2);
        repeat (3) queue_request(bts_pkg::CMD_TICK, '0, '0);
        // tuned frequency past 16 bits with a clock below it
        wait_drained();
        apply_settings(bts_pkg::TCLK_W'(1), 16'hFFFF, 16'hFFFF, bts_pkg::GAP_W'(1));
        queue_request(bts_pkg::CMD_LOAD, 16'd1, '0);
        repeat (2) queue_request(bts_pkg::CMD_TICK, '0, '0);
        // halving down to 1 and saturated counts
        wait_drained();
        apply_settings(bts_pkg::TCLK_W'(100000000), 16'd1, 16'd1, '0);
        queue_request(bts_pkg::CMD_LOAD, 16'hFFFF, '0);
        repeat (2) queue_request(bts_pkg::CMD_TICK, '0, '0);

        run_phase(bts_pkg::TCLK_RESET, bts_pkg::BAND_LOW_RESET, bts_pkg::BAND_HIGH_RESET,
                  bts_pkg::GAP_RESET, 240, 10, 10);
        run_phase(bts_pkg::TCLK_W'(100000000), 16'd1, 16'hFFFF, '0, 160, 0, 25);
        run_phase(bts_pkg::TCLK_W'(1), 16'hFFFF, 16'd1, bts_pkg::GAP_W'(1), 120, 25, 0);
        run_phase(bts_pkg::TCLK_W'($urandom_range(100000000, 1)),
                  bts_pkg::HZ_W'($urandom_range(65535, 1)),
                  bts_pkg::HZ_W'($urandom_range(65535, 1)),
                  bts_pkg::GAP_W'($urandom_range(10)), 200, 15, 15);
        run_phase(bts_pkg::TCLK_RESET, 16'd2000, 16'd9000, bts_pkg::GAP_W'(255), 220, 10, 10);
        run_phase(bts_pkg::TCLK_W'($urandom_range(100000000, 1)),
                  bts_pkg::HZ_W'($urandom_range(65535, 1)),
                  bts_pkg::HZ_W'($urandom_range(65535, 1)),
                  bts_pkg::GAP_W'(2), 160, 0, 0);
        wait_drained();
      end
      begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    if (timed_out) begin
      failures++;
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, due_status.size());
    end
    $display("ran %0d requests over %0d register settings: %0d tones, %0d rests, %0d refused",
             requests_sent, settings_used, tones_loaded, rests_loaded, loads_refused);
    $display("checked %0d results, %0d tones ran to the end, %0d failures",
             results_checked, tones_finished, failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
